>>> sv/apu_pkg.sv
package apu_pkg;

  localparam int PosW   = 32;
  localparam int AngW   = 20;
  localparam int TimeW  = 16;
  localparam int ThrW   = 19;
  localparam int TrigW  = 33;
  localparam int ZW     = 36;
  localparam int AtanEntries = 24;

  localparam logic signed [ZW-1:0] Q24Pi     = 36'sd52707179;
  localparam logic signed [ZW-1:0] Q24TwoPi  = 36'sd105414358;
  localparam logic signed [ZW-1:0] Q24HalfPi = 36'sd26353589;
  localparam logic signed [TrigW-1:0] CordicGain = 33'sd652032874;

  typedef struct packed {
    logic signed [PosW-1:0]  start_x;
    logic signed [PosW-1:0]  start_y;
    logic signed [AngW-1:0]  start_heading;
    logic signed [AngW-1:0]  lin_speed;
    logic signed [AngW-1:0]  ang_speed;
    logic        [TimeW-1:0] step_time;
  } apu_in_t;

  typedef struct packed {
    logic signed [PosW-1:0] end_x;
    logic signed [PosW-1:0] end_y;
    logic signed [AngW-1:0] end_heading;
    logic                   overflow;
  } apu_out_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        5'd0: r = 36'sd13176795;
        5'd1: r = 36'sd7778716;
        5'd2: r = 36'sd4110060;
        5'd3: r = 36'sd2086331;
        5'd4: r = 36'sd1047214;
        5'd5: r = 36'sd524117;
        5'd6: r = 36'sd262123;
        5'd7: r = 36'sd131069;
        default: r = (i < 5'd24) ? (36'sd1 <<< (5'd24 - i)) : 36'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> sv/apu_front.sv
module apu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  apu_pkg::apu_in_t in_data,
  input  logic [18:0]     thr,
  output logic            q_valid,
  output apu_pkg::apu_in_t q_data,
  output logic            q_arc
);
  import apu_pkg::*;

  logic                q_valid_r;
  apu_in_t             q_data_r;
  logic                q_arc_r;
  logic [AngW:0]       aw;

  // classify: arc when angular speed is non-zero and not below threshold
  always_comb begin
    aw = in_data.ang_speed[AngW-1] ? -{in_data.ang_speed[AngW-1], in_data.ang_speed}
                                   :  {in_data.ang_speed[AngW-1], in_data.ang_speed};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= in_valid;
    end
    q_data_r <= in_data;
    q_arc_r  <= (in_data.ang_speed != '0) && (aw >= {2'b00, thr});
  end

  assign q_valid = q_valid_r;
  assign q_data  = q_data_r;
  assign q_arc   = q_arc_r;
endmodule

>>> sv/apu_back.sv
module apu_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  apu_pkg::apu_in_t q_data,
  input  logic             q_arc,
  output logic             out_valid,
  output apu_pkg::apu_out_t out_data
);
  import apu_pkg::*;

  localparam int NS = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int DivW = 64;
  localparam int DL = DivW;
  localparam int NhW = AngW + 6;

  // stage 1: products and new heading
  logic             v1_r;
  apu_in_t          d1_r;
  logic             a1_r;
  logic signed [ZW-1:0] z0_r, z1_r;
  logic signed [NhW-1:0] nh1_r;
  logic signed [PosW+4:0] dist1_r;

  logic signed [AngW+TimeW:0] wdt, vdt;
  logic signed [NhW-1:0] nh_c;
  always_comb begin
    wdt  = q_data.ang_speed * $signed({1'b0, q_data.step_time});
    vdt  = q_data.lin_speed * $signed({1'b0, q_data.step_time});
    nh_c = NhW'(q_data.start_heading) + (q_arc ? NhW'(wdt >>> 12) : NhW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= q_valid;
    d1_r    <= q_data;
    a1_r    <= q_arc;
    nh1_r   <= nh_c;
    dist1_r <= (PosW+5)'(vdt >>> 12);
    z0_r    <= ZW'(q_data.start_heading) <<< 8;
    z1_r    <= ZW'(nh_c) <<< 8;
  end

  // fold the arc angle to within one turn of zero
  function automatic logic signed [ZW-1:0] fold(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    begin
      t = z;
      for (int k = 4; k >= 0; k--) begin
        if (t >= (Q24TwoPi <<< k)) t = t - (Q24TwoPi <<< k);
        else if (t <= -(Q24TwoPi <<< k)) t = t + (Q24TwoPi <<< k);
      end
      return t;
    end
  endfunction

  logic             vk_r, ak_r;
  apu_in_t          dk_r;
  logic signed [NhW-1:0] nhk_r;
  logic signed [PosW+4:0] distk_r;
  logic signed [ZW-1:0] z0k_r, z1k_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vk_r <= 1'b0;
    else        vk_r <= v1_r;
    ak_r <= a1_r; dk_r <= d1_r; nhk_r <= nh1_r; distk_r <= dist1_r;
    z0k_r <= z0_r;
    z1k_r <= fold(z1_r);
  end

  // stage 2: range reduction into [-pi/2, pi/2]
  function automatic logic signed [ZW:0] reduce(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    logic f;
    begin
      t = z;
      f = 1'b0;
      if (t >= Q24Pi) t = t - Q24TwoPi;
      if (t < -Q24Pi) t = t + Q24TwoPi;
      if (t > Q24HalfPi) begin t = t - Q24Pi; f = 1'b1; end
      else if (t < -Q24HalfPi) begin t = t + Q24Pi; f = 1'b1; end
      return {f, t};
    end
  endfunction

  logic             v2_r, a2_r;
  apu_in_t          d2_r;
  logic signed [NhW-1:0] nh2_r;
  logic signed [PosW+4:0] dist2_r;
  logic [ZW:0]      r0_r, r1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= vk_r;
    a2_r <= ak_r; d2_r <= dk_r; nh2_r <= nhk_r; dist2_r <= distk_r;
    r0_r <= reduce(z0k_r);
    r1_r <= reduce(z1k_r);
  end

  // cordic pipeline, two rotators side by side
  logic                   cv_r  [NS+1];
  logic                   ca_r  [NS+1];
  apu_in_t                cd_r  [NS+1];
  logic signed [NhW-1:0]  cnh_r [NS+1];
  logic signed [PosW+4:0] cds_r [NS+1];
  logic [1:0]             cf_r  [NS+1];
  logic signed [TrigW-1:0] x0_r [NS+1], y0_r [NS+1], x1_r [NS+1], y1_r [NS+1];
  logic signed [ZW-1:0]   zz0_r [NS+1], zz1_r [NS+1];

  always_comb begin
    cv_r[0] = v2_r; ca_r[0] = a2_r; cd_r[0] = d2_r; cnh_r[0] = nh2_r;
    cds_r[0] = dist2_r; cf_r[0] = {r1_r[ZW], r0_r[ZW]};
    x0_r[0] = CordicGain; y0_r[0] = '0; x1_r[0] = CordicGain; y1_r[0] = '0;
    zz0_r[0] = r0_r[ZW-1:0]; zz1_r[0] = r1_r[ZW-1:0];
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else        cv_r[i+1] <= cv_r[i];
      ca_r[i+1] <= ca_r[i]; cd_r[i+1] <= cd_r[i]; cnh_r[i+1] <= cnh_r[i];
      cds_r[i+1] <= cds_r[i]; cf_r[i+1] <= cf_r[i];
      if (zz0_r[i] >= 0) begin
        x0_r[i+1] <= x0_r[i] - (y0_r[i] >>> i);
        y0_r[i+1] <= y0_r[i] + (x0_r[i] >>> i);
        zz0_r[i+1] <= zz0_r[i] - atan_q24(5'(i));
      end else begin
        x0_r[i+1] <= x0_r[i] + (y0_r[i] >>> i);
        y0_r[i+1] <= y0_r[i] - (x0_r[i] >>> i);
        zz0_r[i+1] <= zz0_r[i] + atan_q24(5'(i));
      end
      if (zz1_r[i] >= 0) begin
        x1_r[i+1] <= x1_r[i] - (y1_r[i] >>> i);
        y1_r[i+1] <= y1_r[i] + (x1_r[i] >>> i);
        zz1_r[i+1] <= zz1_r[i] - atan_q24(5'(i));
      end else begin
        x1_r[i+1] <= x1_r[i] + (y1_r[i] >>> i);
        y1_r[i+1] <= y1_r[i] - (x1_r[i] >>> i);
        zz1_r[i+1] <= zz1_r[i] + atan_q24(5'(i));
      end
    end
  end

  // post stage: sign flip and differences
  logic signed [TrigW-1:0] c0, s0, c1, s1;
  always_comb begin
    c0 = cf_r[NS][0] ? -x0_r[NS] : x0_r[NS];
    s0 = cf_r[NS][0] ? -y0_r[NS] : y0_r[NS];
    c1 = cf_r[NS][1] ? -x1_r[NS] : x1_r[NS];
    s1 = cf_r[NS][1] ? -y1_r[NS] : y1_r[NS];
  end

  logic pv_r, pa_r;
  apu_in_t pd_r;
  logic signed [NhW-1:0] pnh_r;
  logic signed [PosW+4:0] pds_r;
  logic signed [TrigW:0] ds_r, dc_r;
  logic signed [TrigW-1:0] pc_r, ps_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else        pv_r <= cv_r[NS];
    pa_r <= ca_r[NS]; pd_r <= cd_r[NS]; pnh_r <= cnh_r[NS]; pds_r <= cds_r[NS];
    ds_r <= (TrigW+1)'(s1) - (TrigW+1)'(s0);
    dc_r <= (TrigW+1)'(c1) - (TrigW+1)'(c0);
    pc_r <= c0; ps_r <= s0;
  end

  // products: numerators for an arc, or distance times trig for a straight move
  logic mv_r, ma_r;
  apu_in_t md_r;
  logic signed [NhW-1:0] mnh_r;
  logic signed [DL-1:0] nx_r, ny_r;
  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else        mv_r <= pv_r;
    ma_r <= pa_r; md_r <= pd_r; mnh_r <= pnh_r;
    if (pa_r) begin
      nx_r <= DL'(pd_r.lin_speed) * DL'(ds_r);
      ny_r <= DL'(pd_r.lin_speed) * DL'(dc_r);
    end else begin
      nx_r <= (DL'(pds_r) * DL'(pc_r)) >>> 30;
      ny_r <= (DL'(pds_r) * DL'(ps_r)) >>> 30;
    end
  end

  // pipelined restoring divider on magnitudes, one quotient bit per stage
  localparam int QW = 56;
  localparam int DVW = AngW + 14;
  logic              dv_r  [QW+1];
  logic              da_r  [QW+1];
  apu_in_t           dd_r  [QW+1];
  logic signed [NhW-1:0] dnh_r [QW+1];
  logic [1:0]        dsg_r [QW+1];
  logic [QW-1:0]     qx_r  [QW+1], qy_r [QW+1];
  logic [DVW:0]      rx_r  [QW+1], ry_r [QW+1];
  logic [DVW-1:0]    den_r [QW+1];
  logic signed [DL-1:0] sx_r [QW+1], sy_r [QW+1];

  logic [DVW-1:0] den_c;
  logic [DL-1:0]  ax_c, ay_c;
  logic           neg_w;
  always_comb begin
    neg_w = md_r.ang_speed[AngW-1];
    den_c = neg_w ? DVW'(-(DVW'(md_r.ang_speed) <<< 14)) : DVW'(DVW'(md_r.ang_speed) <<< 14);
    ax_c  = nx_r[DL-1] ? -nx_r : nx_r;
    ay_c  = ny_r[DL-1] ? -ny_r : ny_r;
    dv_r[0] = mv_r; da_r[0] = ma_r; dd_r[0] = md_r; dnh_r[0] = mnh_r;
    dsg_r[0] = {ny_r[DL-1] ^ neg_w, nx_r[DL-1] ^ neg_w};
    qx_r[0] = ax_c[QW-1:0]; qy_r[0] = ay_c[QW-1:0];
    rx_r[0] = '0; ry_r[0] = '0; den_r[0] = den_c;
    sx_r[0] = nx_r; sy_r[0] = ny_r;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DVW:0] tx, ty;
    always_comb begin
      tx = {rx_r[k][DVW-1:0], qx_r[k][QW-1]};
      ty = {ry_r[k][DVW-1:0], qy_r[k][QW-1]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else        dv_r[k+1] <= dv_r[k];
      da_r[k+1] <= da_r[k]; dd_r[k+1] <= dd_r[k]; dnh_r[k+1] <= dnh_r[k];
      dsg_r[k+1] <= dsg_r[k]; den_r[k+1] <= den_r[k];
      sx_r[k+1] <= sx_r[k]; sy_r[k+1] <= sy_r[k];
      if (tx >= {1'b0, den_r[k]}) begin
        rx_r[k+1] <= tx - {1'b0, den_r[k]}; qx_r[k+1] <= {qx_r[k][QW-2:0], 1'b1};
      end else begin
        rx_r[k+1] <= tx; qx_r[k+1] <= {qx_r[k][QW-2:0], 1'b0};
      end
      if (ty >= {1'b0, den_r[k]}) begin
        ry_r[k+1] <= ty - {1'b0, den_r[k]}; qy_r[k+1] <= {qy_r[k][QW-2:0], 1'b1};
      end else begin
        ry_r[k+1] <= ty; qy_r[k+1] <= {qy_r[k][QW-2:0], 1'b0};
      end
    end
  end

  // sum and saturate
  logic signed [DL-1:0] dx, dy, px, py;
  logic ox_lo, ox_hi, oy_lo, oy_hi, oh_lo, oh_hi;
  apu_out_t res;
  always_comb begin
    if (da_r[QW]) begin
      dx = dsg_r[QW][0] ? -DL'(qx_r[QW]) : DL'(qx_r[QW]);
      dy = dsg_r[QW][1] ?  DL'(qy_r[QW]) : -DL'(qy_r[QW]);
    end else begin
      dx = sx_r[QW];
      dy = sy_r[QW];
    end
    px = DL'(dd_r[QW].start_x) + dx;
    py = DL'(dd_r[QW].start_y) + dy;
    ox_lo = px < -(DL'(1) <<< 31);
    ox_hi = px > ((DL'(1) <<< 31) - 1);
    oy_lo = py < -(DL'(1) <<< 31);
    oy_hi = py > ((DL'(1) <<< 31) - 1);
    oh_lo = dnh_r[QW] < -(NhW'(524288));
    oh_hi = dnh_r[QW] > NhW'(524287);
    res.end_x = ox_lo ? 32'sh80000000 : ox_hi ? 32'sh7fffffff : px[PosW-1:0];
    res.end_y = oy_lo ? 32'sh80000000 : oy_hi ? 32'sh7fffffff : py[PosW-1:0];
    res.end_heading = oh_lo ? 20'sh80000 : oh_hi ? 20'sh7ffff : dnh_r[QW][AngW-1:0];
    res.overflow = ox_lo | ox_hi | oy_lo | oy_hi | oh_lo | oh_hi;
  end

  logic out_valid_r;
  apu_out_t out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_r[QW];
    out_data_r <= res;
  end
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

>>> sv/arc_pose_update_core.sv
// Arc pose update core.
// Input: pulse start with a pose, speeds and step time on in_data; busy is
// always low, so an item is taken every cycle (one item per cycle sustained).
// Config: cfg_we writes cfg_data into the straight threshold (reset 1);
// write only while no items are in flight.
// Output: out_valid is high for one cycle with the new pose on out_data.
// The result passes through the front register, angle
// product, angle fold, angle reduction, CORDIC stages, trig differences,
// product, one stage per quotient bit of the 56-bit radius divider
// and the saturation register; the divider is the deepest part.
// The receiver cannot stall; results are presented once and dropped after.
// Reset clears all valid flags; payload registers are not reset.
module arc_pose_update_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  apu_pkg::apu_in_t  in_data,
  input  logic              cfg_we,
  input  logic [18:0]       cfg_data,
  output logic              out_valid,
  output apu_pkg::apu_out_t out_data
);
  import apu_pkg::*;

  logic [ThrW-1:0] thr_r;
  logic            q_valid, q_arc;
  apu_in_t         q_data;

  // hold threshold
  always_ff @(posedge clk) begin
    if (!rst_n)      thr_r <= ThrW'(1);
    else if (cfg_we) thr_r <= cfg_data;
  end

  assign busy = 1'b0;

  apu_front u_front (
    .clk, .rst_n, .in_valid(start), .in_data, .thr(thr_r),
    .q_valid, .q_data, .q_arc
  );

  apu_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_arc, .out_valid, .out_data
  );
endmodule

>>> sv/apu_checker.sv
module apu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input apu_pkg::apu_out_t out_data
);
  // no transfer out straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid after reset");
  // never busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy) else $error("busy");
  // a transfer out carries a fully known pose
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data)) else $error("unknown result");
endmodule

bind arc_pose_update_core apu_checker u_chk (.*);

>>> bench/tb_top.sv
module tb_top;
  import apu_pkg::*;

  localparam int CordicStages = 16;
  localparam int PipeDepth    = CordicStages + 63;
  localparam int ThrMax       = 524287;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  apu_in_t     in_data;
  logic        cfg_we;
  logic [18:0] cfg_data;
  logic        out_valid;
  apu_out_t    out_data;

  logic        busy_q;
  longint      threshold;
  apu_out_t    pose_q[$];
  int          errors;
  bit          burst;

  longint atan_tab[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  arc_pose_update_core #(.CORDIC_STAGES(CordicStages)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Rotation-mode CORDIC on a Q16 angle, giving cos and sin in Q30
  function automatic void angle_trig(input longint ang, output longint c, output longint s);
    longint z, cx, cy, sx, sy;
    bit     flip;
    z    = ang * 256;
    cx   = longint'(CordicGain);
    cy   = 0;
    flip = 1'b0;
    z = z % longint'(Q24TwoPi);
    if (z >= longint'(Q24Pi)) z -= longint'(Q24TwoPi);
    if (z < -longint'(Q24Pi)) z += longint'(Q24TwoPi);
    if (z > longint'(Q24HalfPi)) begin
      z -= longint'(Q24Pi);
      flip = 1'b1;
    end else if (z < -longint'(Q24HalfPi)) begin
      z += longint'(Q24Pi);
      flip = 1'b1;
    end
    for (int i = 0; i < CordicStages && i < 24; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (z >= 0) begin
        cx -= sy; cy += sx; z -= atan_tab[i];
      end else begin
        cx += sy; cy -= sx; z += atan_tab[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    c = cx;
    s = cy;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi,
                                  inout bit ovf);
    if (v < lo) begin
      ovf = 1'b1;
      return lo;
    end
    if (v > hi) begin
      ovf = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // Predict the pose reached after one step
  function automatic apu_out_t next_pose(input apu_in_t p);
    longint   px, py, hd, v, w, dt, aw, dx, dy, nh, run_len, c0, s0, c1, s1;
    bit       ovf;
    apu_out_t r;
    px  = longint'(p.start_x);
    py  = longint'(p.start_y);
    hd  = longint'(p.start_heading);
    v   = longint'(p.lin_speed);
    w   = longint'(p.ang_speed);
    dt  = longint'({1'b0, p.step_time});
    aw  = (w < 0) ? -w : w;
    ovf = 1'b0;
    if (w == 0 || aw < threshold) begin
      run_len = (v * dt) >>> 12;
      angle_trig(hd, c0, s0);
      dx = (run_len * c0) >>> 30;
      dy = (run_len * s0) >>> 30;
      nh = hd;
    end else begin
      nh = hd + ((w * dt) >>> 12);
      angle_trig(hd, c0, s0);
      angle_trig(nh, c1, s1);
      dx = (v * (s1 - s0)) / (w * 16384);
      dy = -((v * (c1 - c0)) / (w * 16384));
    end
    px = clip(px + dx, -64'sd2147483648, 64'sd2147483647, ovf);
    py = clip(py + dy, -64'sd2147483648, 64'sd2147483647, ovf);
    nh = clip(nh, -64'sd524288, 64'sd524287, ovf);
    r.end_x       = px[31:0];
    r.end_y       = py[31:0];
    r.end_heading = nh[19:0];
    r.overflow    = ovf;
    return r;
  endfunction

  // Sample busy mid-cycle so the accept decision never races the edge
  always @(negedge clk) busy_q <= busy;

  // Compare each result with the oldest predicted pose
  always @(negedge clk) begin
    apu_out_t want;
    if (rst_n && out_valid) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = pose_q.pop_front();
        if (out_data.end_x !== want.end_x) begin
          $display("%0t: end_x exp %0d got %0d", $time, want.end_x, out_data.end_x);
          errors++;
        end
        if (out_data.end_y !== want.end_y) begin
          $display("%0t: end_y exp %0d got %0d", $time, want.end_y, out_data.end_y);
          errors++;
        end
        if (out_data.end_heading !== want.end_heading) begin
          $display("%0t: end_heading exp %0d got %0d", $time, want.end_heading,
                   out_data.end_heading);
          errors++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t: overflow exp %0b got %0b", $time, want.overflow,
                   out_data.overflow);
          errors++;
        end
      end
    end
  end

  // Transfer one pose, then hold off for a random gap, which may be zero
  task automatic send_pose(input apu_in_t p);
    int gap;
    start   <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy_q);
    pose_q = {pose_q, next_pose(p)};
    if (burst) gap = 0;
    else if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 60);
    else if ($urandom_range(0, 1) == 0) gap = 0;
    else gap = $urandom_range(1, 3);
    if ($urandom_range(0, 40) == 0) burst = ~burst;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 10) @(posedge clk);
  endtask

  task automatic set_threshold(input int unsigned value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value[18:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    threshold = value;
  endtask

  function automatic apu_in_t make_pose(input apu_in_t p, input int mode);
    apu_in_t r;
    r = p;
    r.start_x       = $urandom;
    r.start_y       = $urandom;
    r.start_heading = 20'($urandom);
    r.lin_speed     = 20'($urandom);
    r.step_time     = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom);
    case (mode)
      0: r.ang_speed = 20'($urandom);
      1: r.ang_speed = 20'($urandom_range(0, 2 * threshold + 4) - threshold - 2);
      default: r.ang_speed = ($urandom_range(0, 1) == 0) ? 20'sd0
                                                         : 20'($urandom_range(0, 63));
    endcase
    // Push some starts towards the position limits so sums saturate
    if ($urandom_range(0, 7) == 0) r.start_x = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'h3fffffff};
    if ($urandom_range(0, 7) == 0) r.start_y = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'h3fffffff};
    return r;
  endfunction

  // Field extremes, zero speeds, zero step, saturation and quadrant edges
  task automatic test_directed;
    apu_in_t p;
    p = '0;
    send_pose(p);
    p.lin_speed = 20'sd65536; p.step_time = 16'd4096;
    send_pose(p);
    p.ang_speed = 20'sd65536;
    send_pose(p);
    p.ang_speed = -20'sd65536;
    send_pose(p);
    p.step_time = 16'd0; p.start_x = 32'sd12345; p.start_y = -32'sd999;
    send_pose(p);
    p = '{start_x: 32'h7fffffff, start_y: 32'h7fffffff, start_heading: 20'sd0,
          lin_speed: 20'sd524287, ang_speed: 20'sd0, step_time: 16'hffff};
    send_pose(p);
    p.start_heading = 20'sd102944;
    send_pose(p);
    p = '{start_x: 32'h80000000, start_y: 32'h80000000, start_heading: -20'sd524288,
          lin_speed: -20'sd524288, ang_speed: -20'sd524288, step_time: 16'hffff};
    send_pose(p);
    p.ang_speed = 20'sd524287; p.start_heading = 20'sd524287;
    send_pose(p);
    p.lin_speed = 20'sd524287; p.ang_speed = -20'sd524288;
    send_pose(p);
    p.start_x = 32'sd0; p.start_y = 32'sd0; p.step_time = 16'd4096;
    p.start_heading = 20'sd102943; p.ang_speed = 20'sd1;
    send_pose(p);
    p.start_heading = -20'sd102944; p.ang_speed = -20'sd1;
    send_pose(p);
    p.start_heading = 20'sd205887; p.ang_speed = 20'sd2;
    send_pose(p);
    p.start_heading = -20'sd205888; p.ang_speed = 20'sd0;
    send_pose(p);
    p.start_heading = 20'sd411775;
    send_pose(p);
    p.ang_speed = 20'sd524287; p.lin_speed = 20'sd1; p.step_time = 16'd1;
    send_pose(p);
  endtask

  task automatic test_random_arcs(input int count);
    apu_in_t p;
    p = '0;
    repeat (count) begin
      p = make_pose(p, $urandom_range(0, 9) == 0 ? 2 : 0);
      send_pose(p);
    end
  endtask

  task automatic test_threshold_edges(input int count);
    apu_in_t p;
    p = '0;
    repeat (count) begin
      p = make_pose(p, $urandom_range(0, 2) == 0 ? 0 : 1);
      send_pose(p);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    busy_q   = 1'b1;
    errors   = 0;
    burst    = 1'b0;
    threshold = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_arcs(500);
    // Pause the sender until the pipeline has emptied
    drain();
    test_random_arcs(100);
    set_threshold(0);
    test_directed();
    test_threshold_edges(150);
    set_threshold(ThrMax);
    test_threshold_edges(150);
    test_directed();
    set_threshold(65536);
    test_threshold_edges(150);
    set_threshold($urandom_range(2, ThrMax - 1));
    test_threshold_edges(150);
    set_threshold(1);
    test_random_arcs(200);

    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
